FILE: rtl/core/binomial_coefficient_macros.svh
// Assertion macros shared by the binomial coefficient RTL.
`ifndef BINOMIAL_COEFFICIENT_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MACROS_SVH

// Check cons in the same cycle as ante.
`define BNC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("binomial_coefficient: assertion failed");

// Check cons in the cycle after ante.
`define BNC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("binomial_coefficient: assertion failed");

`endif

FILE: rtl/core/bnc_pkg.sv
// Types, constants and control program of the binomial coefficient block.
`default_nettype none

package bnc_pkg;

    localparam int ARG_BITS  = 8;
    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int PC_BITS   = 3;

    typedef logic [PC_BITS-1:0] pc_t;

    localparam pc_t PC_LOAD    = PC_BITS'(0);
    localparam pc_t PC_CHECK   = PC_BITS'(1);
    localparam pc_t PC_REDUCE  = PC_BITS'(2);
    localparam pc_t PC_INIT    = PC_BITS'(3);
    localparam pc_t PC_MUL     = PC_BITS'(4);
    localparam pc_t PC_DIVINIT = PC_BITS'(5);
    localparam pc_t PC_DIV     = PC_BITS'(6);
    localparam pc_t PC_OUT     = PC_BITS'(7);

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_CHECK,
        OP_REDUCE,
        OP_INIT,
        OP_MUL,
        OP_DIVINIT,
        OP_DIV,
        OP_OUT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_TRIV,
        C_ONE,
        C_LOOP_MUL,
        C_LOOP_DIV,
        C_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    typedef struct packed {
        logic triv;
        logic one;
        logic i_last;
        logic div_last;
    } status_t;

    function automatic ctrl_t prog_rom(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            PC_LOAD:    w = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: PC_LOAD};
            PC_CHECK:   w = '{op: OP_CHECK,   cond: C_TRIV,     target: PC_OUT};
            PC_REDUCE:  w = '{op: OP_REDUCE,  cond: C_NEXT,     target: PC_LOAD};
            PC_INIT:    w = '{op: OP_INIT,    cond: C_ONE,      target: PC_OUT};
            PC_MUL:     w = '{op: OP_MUL,     cond: C_LOOP_MUL, target: PC_MUL};
            PC_DIVINIT: w = '{op: OP_DIVINIT, cond: C_NEXT,     target: PC_LOAD};
            PC_DIV:     w = '{op: OP_DIV,     cond: C_LOOP_DIV, target: PC_DIV};
            PC_OUT:     w = '{op: OP_OUT,     cond: C_WAIT_OUT, target: PC_LOAD};
            default:    w = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: PC_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bnc_datapath.sv
// Datapath of the binomial coefficient block: products, overflow flag and divider.
`default_nettype none

module bnc_datapath (
    input  wire                                   aclk,
    input  wire bnc_pkg::ctrl_t                   ctrl,
    input  wire                                   step_en,
    input  wire logic signed [bnc_pkg::ARG_BITS-1:0] s_n_value,
    input  wire logic signed [bnc_pkg::ARG_BITS-1:0] s_k_value,
    output bnc_pkg::status_t                      status,
    output logic [bnc_pkg::WORD_BITS-1:0]         quo,
    output logic                                  ovf
);

    localparam int AB = bnc_pkg::ARG_BITS;
    localparam int WB = bnc_pkg::WORD_BITS;
    localparam int PB = bnc_pkg::WORD_BITS + bnc_pkg::ARG_BITS;

    logic signed [AB-1:0]            n_reg, n_next;
    logic signed [AB-1:0]            m_reg, m_next;
    logic        [AB-1:0]            i_reg, i_next;
    logic        [WB-1:0]            num_reg, num_next;
    logic        [WB-1:0]            den_reg, den_next;
    logic        [WB-1:0]            quo_reg, quo_next;
    logic        [WB-1:0]            rem_reg, rem_next;
    logic        [bnc_pkg::CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                            ovf_reg, ovf_next;

    logic signed [AB-1:0] diff;
    logic        [AB-1:0] fac;
    logic        [PB-1:0] prod_num;
    logic        [PB-1:0] prod_den;
    logic        [WB:0]   trial;
    logic                 ge;

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        m_reg   <= m_next;
        i_reg   <= i_next;
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
    end

    always_comb begin
        diff     = n_reg - m_reg;
        fac      = AB'(n_reg) - i_reg;
        prod_num = PB'(num_reg) * PB'(fac);
        prod_den = PB'(den_reg) * PB'(i_reg);
        trial    = {rem_reg, quo_reg[WB-1]};
        ge       = trial >= {1'b0, den_reg};

        status.triv     = n_reg[AB-1] || (n_reg == '0) || m_reg[AB-1] || (m_reg == '0)
                          || (m_reg >= n_reg);
        status.one      = (m_reg == AB'(1));
        status.i_last   = (i_reg == AB'(1));
        status.div_last = (cnt_reg == '0);

        n_next   = n_reg;
        m_next   = m_reg;
        i_next   = i_reg;
        num_next = num_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;

        if (step_en) begin
            unique case (ctrl.op)
                bnc_pkg::OP_LOAD: begin
                    n_next = s_n_value;
                    m_next = s_k_value;
                end
                bnc_pkg::OP_CHECK: begin
                    quo_next = WB'(1);
                    ovf_next = 1'b0;
                end
                bnc_pkg::OP_REDUCE: begin
                    if (diff < m_reg) begin
                        m_next = diff;
                    end
                end
                bnc_pkg::OP_INIT: begin
                    num_next = WB'(unsigned'(n_reg));
                    den_next = WB'(unsigned'(m_reg));
                    quo_next = WB'(unsigned'(n_reg));
                    i_next   = AB'(m_reg) - AB'(1);
                end
                bnc_pkg::OP_MUL: begin
                    num_next = prod_num[WB-1:0];
                    den_next = prod_den[WB-1:0];
                    ovf_next = ovf_reg || (|prod_num[PB-1:WB]) || (|prod_den[PB-1:WB]);
                    i_next   = i_reg - AB'(1);
                end
                bnc_pkg::OP_DIVINIT: begin
                    quo_next = num_reg;
                    rem_next = '0;
                    cnt_next = '1;
                end
                bnc_pkg::OP_DIV: begin
                    rem_next = ge ? WB'(trial - {1'b0, den_reg}) : trial[WB-1:0];
                    quo_next = {quo_reg[WB-2:0], ge};
                    cnt_next = cnt_reg - 1'b1;
                end
                bnc_pkg::OP_OUT: begin
                    quo_next = quo_reg;
                end
                default: begin
                    quo_next = quo_reg;
                end
            endcase
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/core/binomial_coefficient.sv
// Top level of the binomial coefficient block: microcoded sequencer and result register.
//
// Input channel s_*: one transaction carries n (s_n_value) and m (s_k_value), both
// two's complement. Result channel m_*: one transaction per input carries n choose m
// (m_coefficient) and a flag (m_wrapped) set when a 64-bit product overflowed.
// A step counter walks a small control program. Trivial arguments go from the
// check step straight to the output step, m reduced to one goes on through the
// reduce and init steps to the output step, and the general case runs
// one multiply step per factor pair, then one quotient bit per cycle in a
// 64-step restoring divider.
// One item is in work at a time; s_ready is high only on the load step.
// The result sits in an output register, so the next item is taken as soon as the
// previous result has been written there, even while m_ready is low.
// A stalled receiver holds the result; the final step waits until the register frees.
// Reset (aresetn low, synchronous) returns the counter to the load step and drops
// m_valid; no work in progress survives it.
`default_nettype none
`include "binomial_coefficient_macros.svh"

module binomial_coefficient (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  wire logic signed [bnc_pkg::ARG_BITS-1:0] s_n_value,
    input  wire logic signed [bnc_pkg::ARG_BITS-1:0] s_k_value,
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output logic [bnc_pkg::WORD_BITS-1:0]            m_coefficient,
    output logic                                     m_wrapped
);

    bnc_pkg::pc_t     pc_reg, pc_next;
    bnc_pkg::ctrl_t   ctrl;
    bnc_pkg::status_t status;

    logic                           step_en;
    logic                           jump;
    logic                           out_free;
    logic [bnc_pkg::WORD_BITS-1:0]  quo;
    logic                           ovf;

    logic                           m_valid_reg, m_valid_next;
    logic [bnc_pkg::WORD_BITS-1:0]  coef_reg, coef_next;
    logic                           wrapped_reg, wrapped_next;

    bnc_datapath u_datapath (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .step_en   (step_en),
        .s_n_value (s_n_value),
        .s_k_value (s_k_value),
        .status    (status),
        .quo       (quo),
        .ovf       (ovf)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= bnc_pkg::PC_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
        end
        coef_reg    <= coef_next;
        wrapped_reg <= wrapped_next;
    end

    always_comb begin
        ctrl     = bnc_pkg::prog_rom(pc_reg);
        out_free = !m_valid_reg || m_ready;

        case (ctrl.cond)
            bnc_pkg::C_WAIT_IN:  step_en = s_valid;
            bnc_pkg::C_WAIT_OUT: step_en = out_free;
            default:             step_en = 1'b1;
        endcase

        case (ctrl.cond)
            bnc_pkg::C_TRIV:     jump = status.triv;
            bnc_pkg::C_ONE:      jump = status.one;
            bnc_pkg::C_LOOP_MUL: jump = !status.i_last;
            bnc_pkg::C_LOOP_DIV: jump = !status.div_last;
            bnc_pkg::C_WAIT_OUT: jump = 1'b1;
            default:             jump = 1'b0;
        endcase

        if (!step_en) begin
            pc_next = pc_reg;
        end else if (jump) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + 1'b1;
        end

        s_ready = (ctrl.op == bnc_pkg::OP_LOAD);

        m_valid_next = m_valid_reg;
        coef_next    = coef_reg;
        wrapped_next = wrapped_reg;
        if (step_en && (ctrl.op == bnc_pkg::OP_OUT)) begin
            m_valid_next = 1'b1;
            coef_next    = quo;
            wrapped_next = ovf;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_coefficient = coef_reg;
    assign m_wrapped     = wrapped_reg;

    `BNC_ASSERT_NXT(a_load_to_check, s_valid && s_ready, pc_reg == bnc_pkg::PC_CHECK)
    `BNC_ASSERT_NXT(a_out_fills_reg, step_en && (ctrl.op == bnc_pkg::OP_OUT), m_valid_reg)
    `BNC_ASSERT_NXT(a_trivial_skip, (ctrl.op == bnc_pkg::OP_CHECK) && status.triv, pc_reg == bnc_pkg::PC_OUT)

endmodule

`default_nettype wire
